FILE: hw/rtl/rk4_pkg.sv
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared constants, types and fixed-point helpers for the RK4 integrator.
// ----------------------------------------------------------------------------
package rk4_pkg;

	localparam int FRAC_BITS = 24;
	localparam int WORD_BITS = 32;
	localparam int DIV_BITS  = WORD_BITS - 1 + FRAC_BITS + 1;
	localparam int DCNT_W    = $clog2(DIV_BITS);
	localparam int ADDR_W    = 4;

	localparam logic signed [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic signed [WORD_BITS-1:0] ONE  = WORD_BITS'(64'd1 << FRAC_BITS);
	// ceil(2^34 / 6): x / 6 == (x * RECIP6) >> 34 for any 32-bit x
	localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;

	typedef enum logic [1:0] {
		REG_START_TIME    = 2'd0,
		REG_INITIAL_VALUE = 2'd1,
		REG_STEP_SIZE     = 2'd2,
		REG_STEP_COUNT    = 2'd3
	} reg_idx_t;

	// value plus a sticky-saturation bit
	typedef struct packed {
		logic                        sat;
		logic signed [WORD_BITS-1:0] v;
	} sres_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	function automatic sres_t sadd(input logic signed [WORD_BITS-1:0] a,
			input logic signed [WORD_BITS-1:0] b);
		logic signed [WORD_BITS:0] s;
		sres_t r;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		r.sat = 1'b0;
		r.v   = s[WORD_BITS-1:0];
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			r.sat = 1'b1;
			r.v   = s[WORD_BITS] ? MINV : MAXV;
		end
		return r;
	endfunction

	// truncating halve, toward zero
	function automatic logic signed [WORD_BITS-1:0] half(input logic signed [WORD_BITS-1:0] x);
		logic signed [WORD_BITS:0] s;
		s = {x[WORD_BITS-1], x} + {{WORD_BITS{1'b0}}, x[WORD_BITS-1]};
		return s[WORD_BITS:1];
	endfunction

	function automatic logic [WORD_BITS-1:0] magn(input logic signed [WORD_BITS-1:0] x);
		return x[WORD_BITS-1] ? WORD_BITS'(-x) : WORD_BITS'(x);
	endfunction

	// round-half-away on the magnitude product, then apply sign and clamp
	function automatic sres_t fmul_post(input logic [2*WORD_BITS-1:0] prod, input logic neg);
		logic [2*WORD_BITS:0]           p;
		logic [2*WORD_BITS-FRAC_BITS:0] m;
		logic [2*WORD_BITS-FRAC_BITS:0] lim;
		sres_t r;
		p   = {1'b0, prod} + ((2*WORD_BITS+1)'(1) << (FRAC_BITS - 1));
		m   = p[2*WORD_BITS:FRAC_BITS];
		lim = neg ? ((2*WORD_BITS-FRAC_BITS+1)'(1) << (WORD_BITS - 1))
		          : (2*WORD_BITS-FRAC_BITS+1)'(MAXV);
		r.sat = 1'b0;
		r.v   = neg ? WORD_BITS'(-m) : WORD_BITS'(m);
		if (m > lim) begin
			r.sat = 1'b1;
			r.v   = neg ? MINV : MAXV;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/rk4_ode_integrator_core.sv
// ----------------------------------------------------------------------------
// rk4_ode_integrator_core
// Fixed-point RK4 integrator for dy/dt = y*y/(t+1), Q8.24, saturating.
// ----------------------------------------------------------------------------
// Usage:
//  - Program start_time, initial_value, step_size, step_count over APB
//    (byte addresses 0, 4, 8, 12) while the core is idle.
//  - Input channel (in_valid/in_stall, field restart): restart=1 reloads
//    the start point and emits it; restart=0 runs one RK4 step, if any
//    remain, and emits the point. in_stall is high while an item runs.
//  - Output channel (out_valid/out_stall): one item per input item, held in an
//    output register; a new input can be taken while it waits.
// Sequence: a restart, or a step past the end, goes straight from accept to
//  the output state. A real step runs four derivative evaluations (square on
//  the shared multiplier, divider load, a 56-bit bit-serial divide plus its
//  done, the h*f product), then the reciprocal multiply for the /6 and the
//  output. An evaluation with t+1 <= 0 skips the divide. The divider
//  dominates a step. No new item is taken until the core has put the last
//  one in the output register.
// Reset: state (t, y, step counter) clears to zero, step_count to 1.
// A stalled output holds; the core finishes its item and waits in the output
//  state until the register is free.
module rk4_ode_integrator_core import rk4_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   time_out,
	output logic signed [31:0]   value_out,
	output logic [15:0]          step_number,
	output logic                 last,
	output logic                 saturated,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_SQ   = 10'b00_0000_0010,
		S_SQR  = 10'b00_0000_0100,
		S_DSET = 10'b00_0000_1000,
		S_DIV  = 10'b00_0001_0000,
		S_KM   = 10'b00_0010_0000,
		S_KR   = 10'b00_0100_0000,
		S_D6   = 10'b00_1000_0000,
		S_D6R  = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [31:0] start_time_q;
	logic signed [31:0] initial_value_q;
	logic [30:0]        step_size_q;
	logic [15:0]        step_count_q;
	reg_idx_t           widx;
	logic               cfg_wr;

	// integrator state and working registers
	logic signed [WORD_BITS-1:0] t_q, w_q, h_q, th_q;
	logic signed [WORD_BITS-1:0] arg_t_q, arg_y_q, sq_q, den_q, f_q, acc_q;
	logic [15:0]                 steps_q;
	logic [1:0]                  kidx_q;
	logic                        sat_q;

	logic [WORD_BITS-1:0]   mul_a, mul_b;
	logic [2*WORD_BITS-1:0] prod_q;
	div_ctl_t               dctl;
	logic                   div_busy;
	logic [DIV_BITS-1:0]    quot;
	logic [DIV_BITS-1:0]    div_num;

	logic                   in_acc;
	sres_t                  th_r, sq_r, den_r, k_r, r1, r2, ya, yb, tb, ws, tn;
	logic [WORD_BITS-3:0]   q6;
	logic signed [WORD_BITS-1:0] q6s;

	// ---------------- APB ----------------
	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (widx)
			REG_START_TIME:    prdata = start_time_q;
			REG_INITIAL_VALUE: prdata = initial_value_q;
			REG_STEP_SIZE:     prdata = {1'b0, step_size_q};
			REG_STEP_COUNT:    prdata = {16'd0, step_count_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q    <= '0;
			initial_value_q <= '0;
			step_size_q     <= '0;
			step_count_q    <= 16'd1;
		end else if (cfg_wr) begin
			unique case (widx)
				REG_START_TIME:    start_time_q    <= pwdata;
				REG_INITIAL_VALUE: initial_value_q <= pwdata;
				REG_STEP_SIZE:     step_size_q     <= pwdata[30:0];
				REG_STEP_COUNT:    step_count_q    <= pwdata[15:0];
				default:           ;
			endcase
		end
	end

	// ---------------- shared arithmetic ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = magn(arg_y_q);
				mul_b = magn(arg_y_q);
			end
			S_KM: begin
				mul_a = h_q;
				mul_b = f_q;
			end
			S_D6: begin
				mul_a = magn(acc_q);
				mul_b = RECIP6;
			end
			default: ;
		endcase
	end

	rk4_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// dividend: (y*y << FRAC) + den/2 for round-half-up
	assign div_num    = (DIV_BITS'(sq_q) << FRAC_BITS) + DIV_BITS'(den_q >>> 1);
	assign dctl.start = (state_q == S_DSET);

	rk4_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dctl.start),
		.num    (div_num),
		.den    (den_q),
		.done_q (dctl.done),
		.busy_q (div_busy),
		.quot   (quot)
	);

	// ---------------- datapath helpers ----------------
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign th_r  = sadd(t_q, WORD_BITS'({1'b0, step_size_q} >> 1));
	assign sq_r  = fmul_post(prod_q, 1'b0);
	assign den_r = sadd(arg_t_q, ONE);
	assign k_r   = fmul_post(prod_q, 1'b0);
	assign r1    = sadd(acc_q, k_r.v);
	assign r2    = sadd(r1.v, k_r.v);
	assign ya    = sadd(w_q, half(k_r.v));
	assign yb    = sadd(w_q, k_r.v);
	assign tb    = sadd(t_q, h_q);
	assign q6    = prod_q[63:34];
	assign q6s   = acc_q[WORD_BITS-1] ? -WORD_BITS'({2'b00, q6}) : WORD_BITS'({2'b00, q6});
	assign ws    = sadd(w_q, q6s);
	assign tn    = tb;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid   <= 1'b0;
			t_q         <= '0;
			w_q         <= '0;
			steps_q     <= '0;
			kidx_q      <= '0;
			sat_q       <= 1'b0;
			h_q         <= '0;
			th_q        <= '0;
			arg_t_q     <= '0;
			arg_y_q     <= '0;
			sq_q        <= '0;
			den_q       <= '0;
			f_q         <= '0;
			acc_q       <= '0;
			time_out    <= '0;
			value_out   <= '0;
			step_number <= '0;
			last        <= 1'b0;
			saturated   <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						sat_q <= 1'b0;
						if (restart) begin
							t_q     <= start_time_q;
							w_q     <= initial_value_q;
							steps_q <= '0;
							state_q <= S_OUT;
						end else if (steps_q >= step_count_q) begin
							state_q <= S_OUT;
						end else begin
							h_q     <= {1'b0, step_size_q};
							th_q    <= th_r.v;
							sat_q   <= th_r.sat;
							arg_t_q <= t_q;
							arg_y_q <= w_q;
							kidx_q  <= '0;
							state_q <= S_SQ;
						end
					end
				end
				S_SQ:  state_q <= S_SQR;
				S_SQR: begin
					sq_q  <= sq_r.v;
					den_q <= den_r.v;
					sat_q <= sat_q | sq_r.sat | den_r.sat;
					if (den_r.v[WORD_BITS-1] || den_r.v == '0) begin
						f_q     <= MAXV;
						sat_q   <= 1'b1;
						state_q <= S_KM;
					end else begin
						state_q <= S_DSET;
					end
				end
				S_DSET: state_q <= S_DIV;
				S_DIV: begin
					if (dctl.done) begin
						if (quot > DIV_BITS'(MAXV)) begin
							f_q   <= MAXV;
							sat_q <= 1'b1;
						end else begin
							f_q <= WORD_BITS'(quot);
						end
						state_q <= S_KM;
					end
				end
				S_KM: state_q <= S_KR;
				S_KR: begin
					kidx_q <= kidx_q + 1'b1;
					state_q <= S_SQ;
					case (kidx_q)
						2'd0: begin
							acc_q   <= k_r.v;
							arg_t_q <= th_q;
							arg_y_q <= ya.v;
							sat_q   <= sat_q | k_r.sat | ya.sat;
						end
						2'd1: begin
							acc_q   <= r2.v;
							arg_y_q <= ya.v;
							sat_q   <= sat_q | k_r.sat | r1.sat | r2.sat | ya.sat;
						end
						2'd2: begin
							acc_q   <= r2.v;
							arg_t_q <= tb.v;
							arg_y_q <= yb.v;
							sat_q   <= sat_q | k_r.sat | r1.sat | r2.sat | yb.sat | tb.sat;
						end
						default: begin
							acc_q   <= r1.v;
							sat_q   <= sat_q | k_r.sat | r1.sat;
							state_q <= S_D6;
						end
					endcase
				end
				S_D6: state_q <= S_D6R;
				S_D6R: begin
					w_q     <= ws.v;
					t_q     <= tn.v;
					sat_q   <= sat_q | ws.sat | tn.sat;
					steps_q <= steps_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid   <= 1'b1;
						time_out    <= t_q;
						value_out   <= w_q;
						step_number <= steps_q;
						last        <= steps_q >= step_count_q;
						saturated   <= sat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- assertions ----------------
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_DIV)
		else $error("divider running outside divide state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted item did not start");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result appeared without finishing an item");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.done |-> state_q == S_DIV)
		else $error("divider result not consumed");

endmodule

FILE: hw/rtl/rk4_mul.sv
// ----------------------------------------------------------------------------
// rk4_mul
// Shared unsigned 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module rk4_mul import rk4_pkg::*; (
	input  logic                       clk,
	input  logic [WORD_BITS-1:0]       a,
	input  logic [WORD_BITS-1:0]       b,
	output logic [2*WORD_BITS-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

FILE: hw/rtl/rk4_div.sv
// ----------------------------------------------------------------------------
// rk4_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rk4_div import rk4_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_BITS-1:0]  num,
	input  logic [WORD_BITS-1:0] den,
	output logic                 done_q,
	output logic                 busy_q,
	output logic [DIV_BITS-1:0]  quot
);

	logic [DIV_BITS-1:0]  num_q;
	logic [WORD_BITS-1:0] den_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [DCNT_W-1:0]    cnt_q;
	logic [WORD_BITS:0]   rem_sh;
	logic                 ge;
	logic [WORD_BITS:0]   rem_nx;

	assign rem_sh = {rem_q, num_q[DIV_BITS-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	assign quot   = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx[WORD_BITS-1:0];
			num_q <= {num_q[DIV_BITS-2:0], ge};
		end
	end

endmodule
